### rtl/core/ack_data_two_queue_scheduler_defines.svh
// ----------------------------------------------------------------------------
// ack_data_two_queue_scheduler_defines
// Assertion macros shared by the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef ACK_DATA_TWO_QUEUE_SCHEDULER_DEFINES_SVH
`define ACK_DATA_TWO_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, off during reset
`define ADTQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ADTQS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always on
`define ADTQS_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/adtqs_pkg.sv
// ----------------------------------------------------------------------------
// adtqs_pkg
// Types, codes and defaults for the ACK/data two-queue scheduler.
// ----------------------------------------------------------------------------
package adtqs_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int IN_HANDLE_W     = 16;
  localparam int COUNT_W         = 7;
  localparam int STATUS_W        = 3;
  localparam int MODE_W          = 2;

  localparam logic [STATUS_W-1:0] STAT_ENQ   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DEQ   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NONIP = 3'd4;

  localparam logic [MODE_W-1:0] MODE_ACK_PRIO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IN_ORDER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR       = 2'd2;

  localparam logic [7:0] TCP_PROTO   = 8'd6;
  localparam int         TCP_ACK_BIT = 4;

  typedef struct packed {
    logic                   is_deq;
    logic                   non_ip;
    logic                   to_ack;
    logic [IN_HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [IN_HANDLE_W-1:0] handle;
    logic                   from_ack;
    logic [COUNT_W-1:0]     data_count;
    logic [COUNT_W-1:0]     ack_count;
  } res_t;

endpackage

### rtl/core/adtqs_front.sv
// ----------------------------------------------------------------------------
// adtqs_front
// Accepts items, classifies them as ACK, data or non-IP (not in in-order
// mode), and buffers the commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module adtqs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 mode,
  input  logic                       push,
  output logic                       full,
  input  logic                       kind,
  input  logic [15:0]                packet_handle,
  input  logic                       frame_is_ipv4,
  input  logic [7:0]                 ip_protocol,
  input  logic [7:0]                 tcp_flags,
  input  logic [15:0]                payload_bytes,
  output logic                       cmd_valid,
  output adtqs_pkg::cmd_t            cmd,
  input  logic                       cmd_pop
);
  import adtqs_pkg::*;

  cmd_t       cmd_in;
  cmd_t       cmd_q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       classify;
  logic       do_push;
  logic       do_pop;

  assign classify = (mode != MODE_IN_ORDER);

  always_comb begin
    cmd_in.is_deq = kind;
    cmd_in.non_ip = classify && !frame_is_ipv4;
    cmd_in.to_ack = classify && frame_is_ipv4 && (ip_protocol == TCP_PROTO) &&
                    tcp_flags[TCP_ACK_BIT] && (payload_bytes == 16'd0);
    cmd_in.handle = packet_handle;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = cmd_q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### rtl/core/adtqs_back.sv
// ----------------------------------------------------------------------------
// adtqs_back
// Executes commands against the ACK and data handle memories and queues
// the results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module adtqs_back #(
  parameter int QUEUE_DEPTH = adtqs_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = adtqs_pkg::HANDLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 mode,
  input  logic                       cmd_valid,
  input  adtqs_pkg::cmd_t            cmd,
  output logic                       cmd_pop,
  output logic                       empty,
  input  logic                       pop,
  output adtqs_pkg::res_t            res
);
  import adtqs_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX  = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic                   state_r, state_nxt;
  logic [AW-1:0]          d_head_r, d_head_nxt, d_tail_r, d_tail_nxt;
  logic [AW-1:0]          a_head_r, a_head_nxt, a_tail_r, a_tail_nxt;
  logic [FW-1:0]          d_fill_r, d_fill_nxt, a_fill_r, a_fill_nxt;
  logic                   turn_r, turn_nxt;
  logic                   sel_ack_r, sel_ack_nxt;

  logic [HANDLE_BITS-1:0] d_mem [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] a_mem [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] d_rdata_r, a_rdata_r, wdata;
  logic                   d_we, a_we, d_rd, a_rd;

  res_t                   res_q_r [2];
  res_t                   res_new;
  logic                   oq_wr_r, oq_rd_r;
  logic [1:0]             oq_cnt_r, oq_cnt_nxt;
  logic                   res_push, res_pop;

  logic                   start, enq_full, d_has, a_has, take_d, take_a;

  assign start    = (state_r == S_IDLE) && cmd_valid && (oq_cnt_r != 2'd2);
  assign cmd_pop  = start;
  assign wdata    = HANDLE_BITS'(cmd.handle);
  assign enq_full = cmd.to_ack ? (a_fill_r == FULL_FILL) : (d_fill_r == FULL_FILL);
  assign d_has    = (d_fill_r != '0);
  assign a_has    = (a_fill_r != '0);

  always_comb begin
    case (mode)
      MODE_IN_ORDER: begin
        take_d = d_has;
        take_a = 1'b0;
      end
      MODE_RR: begin
        if (turn_r) begin
          take_a = a_has;
          take_d = !a_has && d_has;
        end else begin
          take_d = d_has;
          take_a = !d_has && a_has;
        end
      end
      default: begin
        take_a = a_has;
        take_d = !a_has && d_has;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    d_head_nxt  = d_head_r;
    d_tail_nxt  = d_tail_r;
    a_head_nxt  = a_head_r;
    a_tail_nxt  = a_tail_r;
    d_fill_nxt  = d_fill_r;
    a_fill_nxt  = a_fill_r;
    turn_nxt    = turn_r;
    sel_ack_nxt = sel_ack_r;
    d_we        = 1'b0;
    a_we        = 1'b0;
    d_rd        = 1'b0;
    a_rd        = 1'b0;
    res_push    = 1'b0;
    res_new     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!cmd.is_deq) begin
            res_push = 1'b1;
            if (cmd.non_ip) begin
              res_new.status = STAT_NONIP;
            end else if (enq_full) begin
              res_new.status   = STAT_FULL;
              res_new.from_ack = cmd.to_ack;
            end else begin
              res_new.status   = STAT_ENQ;
              res_new.from_ack = cmd.to_ack;
              if (cmd.to_ack) begin
                a_we       = 1'b1;
                a_tail_nxt = (a_tail_r == LAST_IDX) ? '0 : a_tail_r + 1'b1;
                a_fill_nxt = a_fill_r + 1'b1;
              end else begin
                d_we       = 1'b1;
                d_tail_nxt = (d_tail_r == LAST_IDX) ? '0 : d_tail_r + 1'b1;
                d_fill_nxt = d_fill_r + 1'b1;
              end
            end
          end else begin
            if (mode == MODE_RR) begin
              turn_nxt = !turn_r;
            end
            if (take_a) begin
              a_rd        = 1'b1;
              a_head_nxt  = (a_head_r == LAST_IDX) ? '0 : a_head_r + 1'b1;
              a_fill_nxt  = a_fill_r - 1'b1;
              sel_ack_nxt = 1'b1;
              state_nxt   = S_RD;
            end else if (take_d) begin
              d_rd        = 1'b1;
              d_head_nxt  = (d_head_r == LAST_IDX) ? '0 : d_head_r + 1'b1;
              d_fill_nxt  = d_fill_r - 1'b1;
              sel_ack_nxt = 1'b0;
              state_nxt   = S_RD;
            end else begin
              res_push       = 1'b1;
              res_new.status = STAT_EMPTY;
            end
          end
        end
      end
      S_RD: begin
        res_push         = 1'b1;
        res_new.status   = STAT_DEQ;
        res_new.from_ack = sel_ack_r;
        res_new.handle   = IN_HANDLE_W'(sel_ack_r ? a_rdata_r : d_rdata_r);
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res_new.data_count = COUNT_W'(d_fill_nxt);
    res_new.ack_count  = COUNT_W'(a_fill_nxt);
  end

  // result buffer
  assign empty   = (oq_cnt_r == 2'd0);
  assign res     = res_q_r[oq_rd_r];
  assign res_pop = pop && !empty;

  always_comb begin
    case ({res_push, res_pop})
      2'b10:   oq_cnt_nxt = oq_cnt_r + 2'd1;
      2'b01:   oq_cnt_nxt = oq_cnt_r - 2'd1;
      default: oq_cnt_nxt = oq_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      d_head_r  <= '0;
      d_tail_r  <= '0;
      a_head_r  <= '0;
      a_tail_r  <= '0;
      d_fill_r  <= '0;
      a_fill_r  <= '0;
      turn_r    <= 1'b0;
      sel_ack_r <= 1'b0;
      oq_wr_r   <= 1'b0;
      oq_rd_r   <= 1'b0;
      oq_cnt_r  <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      d_head_r  <= d_head_nxt;
      d_tail_r  <= d_tail_nxt;
      a_head_r  <= a_head_nxt;
      a_tail_r  <= a_tail_nxt;
      d_fill_r  <= d_fill_nxt;
      a_fill_r  <= a_fill_nxt;
      turn_r    <= turn_nxt;
      sel_ack_r <= sel_ack_nxt;
      oq_wr_r   <= res_push ? !oq_wr_r : oq_wr_r;
      oq_rd_r   <= res_pop ? !oq_rd_r : oq_rd_r;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[oq_wr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      d_mem[d_tail_r] <= wdata;
    end
    if (d_rd) begin
      d_rdata_r <= d_mem[d_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_tail_r] <= wdata;
    end
    if (a_rd) begin
      a_rdata_r <= a_mem[a_head_r];
    end
  end

endmodule

### rtl/core/ack_data_two_queue_scheduler.sv
// ----------------------------------------------------------------------------
// ack_data_two_queue_scheduler
// Two-class transmit scheduler: pure TCP ACK handles and data handles in
// separate queues, served by ACK priority, data only or round robin.
//
//   channel  handshake          beat
//   -------  -----------------  ------------------------------------------
//   input    push / full        kind, handle, frame/IP/TCP classification
//   result   empty / pop        status, handle, queue, both fill counts
//   config   cfg_we             retrieval mode, 2 bits
//
// An enqueue is handled in the back end's idle state; a dequeue that finds a
// handle also passes the read state for the registered read of handle memory.
// Items pass a 2-entry command queue and results a 2-entry output buffer.
// Synchronous active-low reset empties both queues; no clearing pass.
// ----------------------------------------------------------------------------
module ack_data_two_queue_scheduler #(
  parameter int QUEUE_DEPTH = adtqs_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = adtqs_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [15:0] in_packet_handle,
  input  logic        in_frame_is_ipv4,
  input  logic [7:0]  in_ip_protocol,
  input  logic [7:0]  in_tcp_flags,
  input  logic [15:0] in_payload_bytes,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [15:0] out_packet_handle_out,
  output logic        out_from_ack_queue,
  output logic [6:0]  out_data_count,
  output logic [6:0]  out_ack_count
);
  import adtqs_pkg::*;

  logic [MODE_W-1:0] mode_r;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;
  res_t              res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ACK_PRIO;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  adtqs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .mode          (mode_r),
    .push          (push),
    .full          (full),
    .kind          (in_kind),
    .packet_handle (in_packet_handle),
    .frame_is_ipv4 (in_frame_is_ipv4),
    .ip_protocol   (in_ip_protocol),
    .tcp_flags     (in_tcp_flags),
    .payload_bytes (in_payload_bytes),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  adtqs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_status            = res.status;
  assign out_packet_handle_out = res.handle;
  assign out_from_ack_queue    = res.from_ack;
  assign out_data_count        = res.data_count;
  assign out_ack_count         = res.ack_count;

endmodule

### rtl/core/adtqs_checker.sv
// ----------------------------------------------------------------------------
// adtqs_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "ack_data_two_queue_scheduler_defines.svh"

module adtqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_status,
  input logic [15:0] out_packet_handle_out
);
  import adtqs_pkg::*;

  `ADTQS_ASSERT_NXT_ALWAYS(a_empty_after_rst, clk, !rst_n, empty, "result queue not empty after reset")
  `ADTQS_ASSERT_IMP(a_status_legal, clk, rst_n, !empty, out_status <= STAT_NONIP, "illegal status code")
  `ADTQS_ASSERT_IMP(a_handle_zero, clk, rst_n, !empty && (out_status != STAT_DEQ), out_packet_handle_out == 16'd0, "handle set without dequeue")
  `ADTQS_ASSERT_NXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(out_status), "waiting result changed")

endmodule

bind ack_data_two_queue_scheduler adtqs_checker u_adtqs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .empty                 (empty),
  .pop                   (pop),
  .out_status            (out_status),
  .out_packet_handle_out (out_packet_handle_out)
);
